/* rtl/core/ftla_pkg.sv */
// ----------------------------------------------------------------------------
// ftla_pkg
// Shared types, codes and sizes of the flow table with LRU aging.
// ----------------------------------------------------------------------------
package ftla_pkg;

   // table geometry (row count is a power of two)
   localparam int ROWS      = 1024;
   localparam int ROW_BITS  = $clog2(ROWS);
   localparam int OCC_BITS  = $clog2(ROWS + 1);
   localparam int CNT_BITS  = ROW_BITS + 1;

   // field widths
   localparam int KIND_BITS   = 2;
   localparam int ADDR_BITS   = 32;
   localparam int PORT_BITS   = 16;
   localparam int VLAN_BITS   = 12;
   localparam int HANDLE_BITS = 32;
   localparam int TIME_BITS   = 32;
   localparam int STATUS_BITS = 2;
   localparam int SLOT_BITS   = 10;
   localparam int EXP_BITS    = 11;
   localparam int TO_BITS     = 17;

   // configuration port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ADDR_TIMEOUT = 3'd0;
   localparam logic [TO_BITS-1:0] TIMEOUT_RESET = 17'd60;

   // operation codes
   localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_LOOKUP = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_DELETE = 2'd2;

   // result status codes
   localparam logic [STATUS_BITS-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_FULL      = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_ERROR     = 2'd2;
   localparam logic [STATUS_BITS-1:0] STAT_NOT_FOUND = 2'd3;

   // stored flow key
   typedef struct packed {
      logic [ADDR_BITS-1:0] src_addr;
      logic [ADDR_BITS-1:0] dst_addr;
      logic [PORT_BITS-1:0] src_port;
      logic [PORT_BITS-1:0] dst_port;
      logic [VLAN_BITS-1:0] vlan_id;
   } key_type;

endpackage

/* rtl/core/flow_table_with_lru_aging.sv */
// ----------------------------------------------------------------------------
// flow_table_with_lru_aging
// Session table with bidirectional key match, linear probing and LRU aging.
// ----------------------------------------------------------------------------
// The block handles one item at a time through a sequencer around single-port
// row stores with registered reads. After reset a clearing pass sweeps the row
// valid store; no item is taken meanwhile, register writes are. Every probe
// step and every aging step is a read state and then an evaluate state on the
// row stores. From the request transfer to the response the sequencer runs:
// - insert: hash, aging walk up to the check that ends it, probe, then a touch
//   step. A lookup probes before the aging walk and fetches the handle after
//   it. Moving the row to the head of the LRU list takes a push step, after an
//   unlink step when the row was already on the list and not at its head.
// - insert refused as full: hash and aging walk.
// - delete: hash and probe, then an unlink step when the key is present.
// - null-handle insert or undefined kind: hash only.
// A stalled response adds its wait. The timeout register sits at byte address 0.
module flow_table_with_lru_aging
   import ftla_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [KIND_BITS-1:0]     req_kind,
   input  logic [ADDR_BITS-1:0]     req_src_addr,
   input  logic [ADDR_BITS-1:0]     req_dst_addr,
   input  logic [PORT_BITS-1:0]     req_src_port,
   input  logic [PORT_BITS-1:0]     req_dst_port,
   input  logic [VLAN_BITS-1:0]     req_vlan_id,
   input  logic [HANDLE_BITS-1:0]   req_data_handle,
   input  logic [TIME_BITS-1:0]     req_now_seconds,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STATUS_BITS-1:0]   rsp_status,
   output logic [HANDLE_BITS-1:0]   rsp_found_handle,
   output logic [SLOT_BITS-1:0]     rsp_slot_index,
   output logic [EXP_BITS-1:0]      rsp_expired_count
);

   logic [TO_BITS-1:0] timeout;

   // register port
   ftla_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .timeout     (timeout)
   );

   // table engine
   ftla_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .timeout           (timeout),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_src_addr      (req_src_addr),
      .req_dst_addr      (req_dst_addr),
      .req_src_port      (req_src_port),
      .req_dst_port      (req_dst_port),
      .req_vlan_id       (req_vlan_id),
      .req_data_handle   (req_data_handle),
      .req_now_seconds   (req_now_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_found_handle  (rsp_found_handle),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_expired_count (rsp_expired_count)
   );

endmodule

/* rtl/core/ftla_csr.sv */
// ----------------------------------------------------------------------------
// ftla_csr
// APB-style register port holding the aging timeout.
// ----------------------------------------------------------------------------
module ftla_csr
   import ftla_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output logic [TO_BITS-1:0]       timeout
);

   logic [TO_BITS-1:0] timeout_ff;
   logic [TO_BITS-1:0] timeout_in;
   logic               wr_transfer;

   // write transfer completes in the access phase
   assign wr_transfer = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready  = 1'b1;

   always_comb begin
      timeout_in = timeout_ff;
      if (wr_transfer && (csr_paddr == CSR_ADDR_TIMEOUT)) begin
         timeout_in = csr_pwdata[TO_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   // read back
   assign csr_prdata = (csr_paddr == CSR_ADDR_TIMEOUT) ?
                       {{(CSR_DATA_BITS-TO_BITS){1'b0}}, timeout_ff} : '0;
   assign timeout    = timeout_ff;

endmodule

/* rtl/core/ftla_engine.sv */
// ----------------------------------------------------------------------------
// ftla_engine
// Row stores, LRU links and the sequencer that probes, ages and relinks.
// ----------------------------------------------------------------------------
module ftla_engine
   import ftla_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [TO_BITS-1:0]     timeout,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [KIND_BITS-1:0]   req_kind,
   input  logic [ADDR_BITS-1:0]   req_src_addr,
   input  logic [ADDR_BITS-1:0]   req_dst_addr,
   input  logic [PORT_BITS-1:0]   req_src_port,
   input  logic [PORT_BITS-1:0]   req_dst_port,
   input  logic [VLAN_BITS-1:0]   req_vlan_id,
   input  logic [HANDLE_BITS-1:0] req_data_handle,
   input  logic [TIME_BITS-1:0]   req_now_seconds,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [HANDLE_BITS-1:0] rsp_found_handle,
   output logic [SLOT_BITS-1:0]   rsp_slot_index,
   output logic [EXP_BITS-1:0]    rsp_expired_count
);

   // sequencer states
   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_HASH   = 4'd2;
   localparam logic [3:0] S_AGE_RD = 4'd3;
   localparam logic [3:0] S_AGE_EV = 4'd4;
   localparam logic [3:0] S_PRB_RD = 4'd5;
   localparam logic [3:0] S_PRB_EV = 4'd6;
   localparam logic [3:0] S_LK_EV  = 4'd7;
   localparam logic [3:0] S_TOUCH  = 4'd8;
   localparam logic [3:0] S_UL_EV  = 4'd9;
   localparam logic [3:0] S_PUSH   = 4'd10;
   localparam logic [3:0] S_RESP   = 4'd11;

   localparam logic [ROW_BITS-1:0]   LAST_ROW   = ROW_BITS'(ROWS - 1);
   localparam logic [CNT_BITS-1:0]   LAST_CNT   = CNT_BITS'(ROWS - 1);
   localparam logic [OCC_BITS+2:0]   FULL_LIMIT = (OCC_BITS+3)'(ROWS);
   localparam logic [EXP_BITS-1:0]   EXP_MAX    = '1;

   // row stores
   key_type                mem_key  [ROWS];
   logic [HANDLE_BITS-1:0] mem_hdl  [ROWS];
   logic [TIME_BITS-1:0]   mem_seen [ROWS];
   logic [ROW_BITS-1:0]    mem_prev [ROWS];
   logic [ROW_BITS-1:0]    mem_next [ROWS];
   logic                   mem_vld  [ROWS];

   // registered read data
   key_type                key_rd_ff;
   logic [HANDLE_BITS-1:0] hdl_rd_ff;
   logic [TIME_BITS-1:0]   seen_rd_ff;
   logic [ROW_BITS-1:0]    prev_rd_ff;
   logic [ROW_BITS-1:0]    next_rd_ff;
   logic                   vld_rd_ff;

   // latched item
   logic [KIND_BITS-1:0]   kind_ff;
   key_type                key_ff;
   logic [HANDLE_BITS-1:0] hd_ff;
   logic [TIME_BITS-1:0]   now_ff;

   // control state
   logic [3:0]             state_ff, state_in;
   logic [ROW_BITS-1:0]    r_ff, r_in;
   logic [CNT_BITS-1:0]    n_ff, n_in;
   logic [CNT_BITS-1:0]    clr_ff, clr_in;
   logic [ROW_BITS-1:0]    head_ff, head_in;
   logic [ROW_BITS-1:0]    tail_ff, tail_in;
   logic                   ne_ff, ne_in;
   logic [OCC_BITS-1:0]    occ_ff, occ_in;
   logic [EXP_BITS-1:0]    exp_ff, exp_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic                   member_ff, member_in;

   // write ports
   logic                   we_vld, vld_wd, we_key, we_seen, we_next, we_prev;
   logic [ROW_BITS-1:0]    vld_wa, next_wa, next_wd, prev_wa, prev_wd;
   logic [ROW_BITS-1:0]    raddr;

   // hash, match and age
   logic [ADDR_BITS-1:0]          addr_sum, hmix;
   logic [PORT_BITS:0]            port_sum;
   logic [VLAN_BITS:0]            vl_plus;
   logic [ROW_BITS+VLAN_BITS:0]   hprod;
   logic [TIME_BITS-1:0]          age;
   logic                          expire, hit, fwd_eq, rev_eq, is_full;
   logic [ROW_BITS-1:0]           r_wrap;

   // home row from the latched key
   assign addr_sum = key_ff.src_addr + key_ff.dst_addr;
   assign port_sum = {1'b0, key_ff.src_port} + {1'b0, key_ff.dst_port};
   assign hmix     = addr_sum ^ {{(ADDR_BITS-PORT_BITS-1){1'b0}}, port_sum};
   assign vl_plus  = {1'b0, key_ff.vlan_id} + {{VLAN_BITS{1'b0}}, 1'b1};
   assign hprod    = {{(VLAN_BITS+1){1'b0}}, hmix[ROW_BITS-1:0]} *
                     {{ROW_BITS{1'b0}}, vl_plus};

   // key compare in both directions
   assign fwd_eq = (key_rd_ff.src_addr == key_ff.src_addr) &&
                   (key_rd_ff.dst_addr == key_ff.dst_addr) &&
                   (key_rd_ff.src_port == key_ff.src_port) &&
                   (key_rd_ff.dst_port == key_ff.dst_port);
   assign rev_eq = (key_rd_ff.src_addr == key_ff.dst_addr) &&
                   (key_rd_ff.dst_addr == key_ff.src_addr) &&
                   (key_rd_ff.src_port == key_ff.dst_port) &&
                   (key_rd_ff.dst_port == key_ff.src_port);
   assign hit    = !vld_rd_ff ||
                   ((key_rd_ff.vlan_id == key_ff.vlan_id) && (fwd_eq || rev_eq));

   assign age     = now_ff - seen_rd_ff;
   assign expire  = ne_ff && (age >= {{(TIME_BITS-TO_BITS){1'b0}}, timeout});
   assign is_full = {occ_ff, 3'b000} > FULL_LIMIT;
   assign r_wrap  = (r_ff == LAST_ROW) ? '0 : r_ff + 1'b1;
   assign raddr   = (state_ff == S_AGE_RD) ? tail_ff : r_ff;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      r_in      = r_ff;
      n_in      = n_ff;
      clr_in    = clr_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      ne_in     = ne_ff;
      occ_in    = occ_ff;
      exp_in    = exp_ff;
      status_in = status_ff;
      handle_in = handle_ff;
      member_in = member_ff;
      we_vld    = 1'b0;
      vld_wa    = r_ff;
      vld_wd    = 1'b0;
      we_key    = 1'b0;
      we_seen   = 1'b0;
      we_next   = 1'b0;
      next_wa   = r_ff;
      next_wd   = head_ff;
      we_prev   = 1'b0;
      prev_wa   = head_ff;
      prev_wd   = r_ff;

      unique case (state_ff)
         S_CLEAR: begin
            we_vld = 1'b1;
            vld_wa = clr_ff[ROW_BITS-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_CNT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               exp_in    = '0;
               handle_in = '0;
               status_in = STAT_ERROR;
               state_in  = S_HASH;
            end
         end
         S_HASH: begin
            r_in = hprod[ROW_BITS-1:0];
            n_in = '0;
            priority if (kind_ff == KIND_INSERT) begin
               state_in = (hd_ff == '0) ? S_RESP : S_AGE_RD;
            end else if (kind_ff == KIND_LOOKUP || kind_ff == KIND_DELETE) begin
               state_in = S_PRB_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_AGE_RD: begin
            state_in = S_AGE_EV;
         end
         S_AGE_EV: begin
            if (expire) begin
               we_vld = 1'b1;
               vld_wa = tail_ff;
               if (occ_ff != '0) begin
                  occ_in = occ_ff - 1'b1;
               end
               if (exp_ff != EXP_MAX) begin
                  exp_in = exp_ff + 1'b1;
               end
               if (tail_ff == head_ff) begin
                  ne_in = 1'b0;
               end else begin
                  tail_in = prev_rd_ff;
               end
               state_in = S_AGE_RD;
            end else if (kind_ff == KIND_INSERT) begin
               if (is_full) begin
                  status_in = STAT_FULL;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_PRB_RD;
               end
            end else begin
               state_in = S_LK_EV;
            end
         end
         S_PRB_RD: begin
            state_in = S_PRB_EV;
         end
         S_PRB_EV: begin
            if (hit) begin
               priority if (kind_ff == KIND_INSERT) begin
                  we_key    = 1'b1;
                  we_vld    = 1'b1;
                  vld_wd    = 1'b1;
                  member_in = vld_rd_ff;
                  if (!vld_rd_ff) begin
                     occ_in = occ_ff + 1'b1;
                  end
                  status_in = STAT_OK;
                  state_in  = S_TOUCH;
               end else if (kind_ff == KIND_LOOKUP) begin
                  state_in = S_AGE_RD;
               end else begin
                  if (vld_rd_ff) begin
                     status_in = STAT_OK;
                     state_in  = S_UL_EV;
                  end else begin
                     status_in = STAT_NOT_FOUND;
                     state_in  = S_RESP;
                  end
               end
            end else if (n_ff == LAST_CNT) begin
               status_in = STAT_ERROR;
               state_in  = S_RESP;
            end else begin
               r_in     = r_wrap;
               n_in     = n_ff + 1'b1;
               state_in = S_PRB_RD;
            end
         end
         S_LK_EV: begin
            if (vld_rd_ff) begin
               handle_in = hdl_rd_ff;
               member_in = 1'b1;
               status_in = STAT_OK;
               state_in  = S_TOUCH;
            end else begin
               status_in = STAT_NOT_FOUND;
               state_in  = S_RESP;
            end
         end
         S_TOUCH: begin
            priority if (member_ff && ne_ff && (head_ff == r_ff)) begin
               we_seen  = 1'b1;
               state_in = S_RESP;
            end else if (member_ff) begin
               state_in = S_UL_EV;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_UL_EV: begin
            // unlink the row; link data was read at this row
            priority if ((head_ff == r_ff) && (tail_ff == r_ff)) begin
               ne_in = 1'b0;
            end else if (head_ff == r_ff) begin
               head_in = next_rd_ff;
            end else if (tail_ff == r_ff) begin
               tail_in = prev_rd_ff;
            end else begin
               we_next = 1'b1;
               next_wa = prev_rd_ff;
               next_wd = next_rd_ff;
               we_prev = 1'b1;
               prev_wa = next_rd_ff;
               prev_wd = prev_rd_ff;
            end
            if (kind_ff == KIND_DELETE) begin
               we_vld = 1'b1;
               if (occ_ff != '0) begin
                  occ_in = occ_ff - 1'b1;
               end
               state_in = S_RESP;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            we_seen = 1'b1;
            if (!ne_ff) begin
               head_in = r_ff;
               tail_in = r_ff;
               ne_in   = 1'b1;
            end else begin
               we_next = 1'b1;
               we_prev = 1'b1;
               head_in = r_ff;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         ne_ff     <= 1'b0;
         occ_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         ne_ff     <= ne_in;
         occ_ff    <= occ_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      r_ff      <= r_in;
      n_ff      <= n_in;
      exp_ff    <= exp_in;
      status_ff <= status_in;
      handle_ff <= handle_in;
      member_ff <= member_in;
      if (req_valid && req_ready) begin
         kind_ff          <= req_kind;
         key_ff.src_addr  <= req_src_addr;
         key_ff.dst_addr  <= req_dst_addr;
         key_ff.src_port  <= req_src_port;
         key_ff.dst_port  <= req_dst_port;
         key_ff.vlan_id   <= req_vlan_id;
         hd_ff            <= req_data_handle;
         now_ff           <= req_now_seconds;
      end
   end

   // row stores: one read address, registered data
   always_ff @(posedge clock) begin
      key_rd_ff  <= mem_key[raddr];
      hdl_rd_ff  <= mem_hdl[raddr];
      seen_rd_ff <= mem_seen[raddr];
      prev_rd_ff <= mem_prev[raddr];
      next_rd_ff <= mem_next[raddr];
      vld_rd_ff  <= mem_vld[raddr];
      if (we_key) begin
         mem_key[r_ff] <= key_ff;
         mem_hdl[r_ff] <= hd_ff;
      end
      if (we_seen) begin
         mem_seen[r_ff] <= now_ff;
      end
      if (we_next) begin
         mem_next[next_wa] <= next_wd;
      end
      if (we_prev) begin
         mem_prev[prev_wa] <= prev_wd;
      end
      if (we_vld) begin
         mem_vld[vld_wa] <= vld_wd;
      end
   end

   // handshake and result
   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = (state_ff == S_RESP);
   assign rsp_status        = status_ff;
   assign rsp_found_handle  = handle_ff;
   assign rsp_slot_index    = (status_ff == STAT_OK) ? SLOT_BITS'(r_ff) : '0;
   assign rsp_expired_count = exp_ff;

endmodule

/* tb/flow_table_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flow_table_checker
// Watches the request, response and register ports of the flow table, keeps
// its own copy of the rows and the LRU list, predicts the response of every
// request transfer and compares each response transfer field by field.
// ----------------------------------------------------------------------------
module flow_table_checker
   import ftla_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic                     csr_pready,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [KIND_BITS-1:0]     req_kind,
   input  logic [ADDR_BITS-1:0]     req_src_addr,
   input  logic [ADDR_BITS-1:0]     req_dst_addr,
   input  logic [PORT_BITS-1:0]     req_src_port,
   input  logic [PORT_BITS-1:0]     req_dst_port,
   input  logic [VLAN_BITS-1:0]     req_vlan_id,
   input  logic [HANDLE_BITS-1:0]   req_data_handle,
   input  logic [TIME_BITS-1:0]     req_now_seconds,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [STATUS_BITS-1:0]   rsp_status,
   input  logic [HANDLE_BITS-1:0]   rsp_found_handle,
   input  logic [SLOT_BITS-1:0]     rsp_slot_index,
   input  logic [EXP_BITS-1:0]      rsp_expired_count,
   output int                       failures,
   output int                       outstanding
);

   typedef struct {
      logic [STATUS_BITS-1:0] status;
      logic [HANDLE_BITS-1:0] handle;
      logic [SLOT_BITS-1:0]   slot;
      logic [EXP_BITS-1:0]    expired;
   } flow_result_type;

   // shadow table
   key_type                tbl_key    [ROWS];
   logic [HANDLE_BITS-1:0] tbl_handle [ROWS];
   logic [TIME_BITS-1:0]   tbl_seen   [ROWS];
   bit                     tbl_used   [ROWS];
   logic [ROW_BITS-1:0]    lru_older  [ROWS];
   logic [ROW_BITS-1:0]    lru_newer  [ROWS];
   logic [ROW_BITS-1:0]    lru_first;
   logic [ROW_BITS-1:0]    lru_last;
   bit                     lru_live;
   int                     occupancy;
   logic [TO_BITS-1:0]     timeout_cfg;

   flow_result_type expected_results[$];

   // bidirectional key compare
   function automatic bit key_hit(int r, key_type k);
      key_type s;
      s = tbl_key[r];
      if (s.vlan_id != k.vlan_id) return 0;
      if (s.src_addr == k.src_addr && s.dst_addr == k.dst_addr &&
          s.src_port == k.src_port && s.dst_port == k.dst_port) return 1;
      return s.src_addr == k.dst_addr && s.dst_addr == k.src_addr &&
             s.src_port == k.dst_port && s.dst_port == k.src_port;
   endfunction

   // hash to home row, then linear probe to first empty or matching row
   task automatic probe_row(input key_type k, output bit ok, output int row);
      logic [63:0] h;
      logic [31:0] mix;
      int          r;
      mix = (k.src_addr + k.dst_addr) ^ (32'(k.src_port) + 32'(k.dst_port));
      h   = 64'(mix) * (64'd1 + 64'(k.vlan_id));
      r   = int'(h % ROWS);
      ok  = 0;
      row = 0;
      for (int n = 0; n < ROWS; n++) begin
         if (!tbl_used[r] || key_hit(r, k)) begin
            ok  = 1;
            row = r;
            return;
         end
         r = (r + 1) % ROWS;
      end
   endtask

   task automatic lru_remove(int x);
      if (lru_first == x && lru_last == x) begin
         lru_live = 0;
      end else if (lru_first == x) begin
         lru_first = lru_newer[x];
      end else if (lru_last == x) begin
         lru_last = lru_older[x];
      end else begin
         lru_newer[lru_older[x]] = lru_newer[x];
         lru_older[lru_newer[x]] = lru_older[x];
      end
   endtask

   task automatic lru_make_head(int x);
      if (!lru_live) begin
         lru_first = x;
         lru_last  = x;
         lru_live  = 1;
      end else begin
         lru_newer[x]         = lru_first;
         lru_older[lru_first] = x;
         lru_first            = x;
      end
   endtask

   task automatic lru_refresh(int x, bit member, logic [TIME_BITS-1:0] nw);
      if (member) begin
         if (!(lru_live && lru_first == x)) begin
            lru_remove(x);
            lru_make_head(x);
         end
      end else begin
         lru_make_head(x);
      end
      tbl_seen[x] = nw;
   endtask

   // expire from the oldest end while age reaches the timeout
   task automatic expire_old(input logic [TIME_BITS-1:0] nw, output int cnt);
      logic [TIME_BITS-1:0] age;
      int                   t;
      cnt = 0;
      while (lru_live) begin
         t   = lru_last;
         age = nw - tbl_seen[t];
         if (age < 32'(timeout_cfg)) break;
         tbl_used[t] = 0;
         if (occupancy > 0) occupancy--;
         if (cnt < 2047) cnt++;
         if (t == lru_first) lru_live = 0;
         else lru_last = lru_older[t];
      end
   endtask

   task automatic predict_flow(input logic [KIND_BITS-1:0] kind, input key_type k,
                               input logic [HANDLE_BITS-1:0] hd,
                               input logic [TIME_BITS-1:0] nw);
      flow_result_type res;
      bit              ok;
      bit              member;
      int              row;
      int              cnt;
      res = '{STAT_ERROR, '0, '0, '0};
      cnt = 0;
      case (kind)
         KIND_INSERT: begin
            if (hd != 0) begin
               expire_old(nw, cnt);
               if (occupancy * 8 > ROWS) begin
                  res.status = STAT_FULL;
               end else begin
                  probe_row(k, ok, row);
                  if (ok) begin
                     member          = tbl_used[row];
                     tbl_key[row]    = k;
                     tbl_handle[row] = hd;
                     if (!member) occupancy++;
                     tbl_used[row]   = 1;
                     lru_refresh(row, member, nw);
                     res.status = STAT_OK;
                     res.slot   = row[SLOT_BITS-1:0];
                  end
               end
            end
         end
         KIND_LOOKUP: begin
            probe_row(k, ok, row);
            if (ok) begin
               expire_old(nw, cnt);
               if (tbl_used[row]) begin
                  lru_refresh(row, 1, nw);
                  res.status = STAT_OK;
                  res.handle = tbl_handle[row];
                  res.slot   = row[SLOT_BITS-1:0];
               end else begin
                  res.status = STAT_NOT_FOUND;
               end
            end
         end
         KIND_DELETE: begin
            probe_row(k, ok, row);
            if (ok) begin
               if (tbl_used[row]) begin
                  lru_remove(row);
                  tbl_used[row] = 0;
                  if (occupancy > 0) occupancy--;
                  res.status = STAT_OK;
                  res.slot   = row[SLOT_BITS-1:0];
               end else begin
                  res.status = STAT_NOT_FOUND;
               end
            end
         end
         default: ;
      endcase
      res.expired = cnt[EXP_BITS-1:0];
      expected_results.push_back(res);
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      failures++;
   endtask

   // observe transfers on all three ports
   always @(posedge clock) begin
      flow_result_type want;
      key_type         k;
      if (reset) begin
         foreach (tbl_used[i]) tbl_used[i] = 0;
         lru_first   = '0;
         lru_last    = '0;
         lru_live    = 0;
         occupancy   = 0;
         timeout_cfg = TIMEOUT_RESET;
         expected_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == CSR_ADDR_TIMEOUT)
            timeout_cfg = csr_pwdata[TO_BITS-1:0];
         if (req_valid && req_ready) begin
            k = '{req_src_addr, req_dst_addr, req_src_port, req_dst_port, req_vlan_id};
            predict_flow(req_kind, k, req_data_handle, req_now_seconds);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected response", 32'(rsp_status), 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_status != want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               if (rsp_found_handle != want.handle)
                  report_mismatch("found_handle", rsp_found_handle, want.handle);
               if (rsp_slot_index != want.slot)
                  report_mismatch("slot_index", 32'(rsp_slot_index), 32'(want.slot));
               if (rsp_expired_count != want.expired)
                  report_mismatch("expired_count", 32'(rsp_expired_count),
                                  32'(want.expired));
            end
         end
      end
      outstanding = expected_results.size();
   end

endmodule

/* tb/flow_table_with_lru_aging_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flow_table_with_lru_aging_tb
// Drives directed and random insert, lookup and delete requests through the
// flow table under several timeout settings and idle patterns; the checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module flow_table_with_lru_aging_tb;
   import ftla_pkg::*;

   localparam int POOL = 200;

   // operation code with no defined meaning
   localparam logic [KIND_BITS-1:0] KIND_RESERVED = 2'd3;

   logic                     clock;
   logic                     reset;
   logic                     csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;
   logic                     req_valid, req_ready;
   logic [KIND_BITS-1:0]     req_kind;
   logic [ADDR_BITS-1:0]     req_src_addr, req_dst_addr;
   logic [PORT_BITS-1:0]     req_src_port, req_dst_port;
   logic [VLAN_BITS-1:0]     req_vlan_id;
   logic [HANDLE_BITS-1:0]   req_data_handle;
   logic [TIME_BITS-1:0]     req_now_seconds;
   logic                     rsp_valid, rsp_ready;
   logic [STATUS_BITS-1:0]   rsp_status;
   logic [HANDLE_BITS-1:0]   rsp_found_handle;
   logic [SLOT_BITS-1:0]     rsp_slot_index;
   logic [EXP_BITS-1:0]      rsp_expired_count;
   int                       failures;
   int                       outstanding;

   int                       sender_idle_pct;
   int                       receiver_stall_pct;
   bit                       hold_off_go;
   logic [TIME_BITS-1:0]     now_s;
   key_type                  flow_pool [POOL];

   flow_table_with_lru_aging DUT (.*);

   flow_table_checker u_checker (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_pready,
      .csr_paddr, .csr_pwdata, .req_valid, .req_ready, .req_kind,
      .req_src_addr, .req_dst_addr, .req_src_port, .req_dst_port,
      .req_vlan_id, .req_data_handle, .req_now_seconds, .rsp_valid,
      .rsp_ready, .rsp_status, .rsp_found_handle, .rsp_slot_index,
      .rsp_expired_count, .failures, .outstanding
   );

   // clock
   initial clock = 0;
   always #5 clock = ~clock;

   // watchdog
   initial begin
      #100_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // receiver: random stalls, or one long hold-off on request
   initial begin
      rsp_ready = 0;
      forever begin
         @(posedge clock);
         if (hold_off_go) begin
            hold_off_go = 0;
            rsp_ready <= 0;
            repeat (400) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // one request transfer, with a random gap ahead of it
   task automatic send_flow(logic [KIND_BITS-1:0] kind, key_type k,
                            logic [HANDLE_BITS-1:0] hd, logic [TIME_BITS-1:0] nw);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_valid       <= 1;
      req_kind        <= kind;
      req_src_addr    <= k.src_addr;
      req_dst_addr    <= k.dst_addr;
      req_src_port    <= k.src_port;
      req_dst_port    <= k.dst_port;
      req_vlan_id     <= k.vlan_id;
      req_data_handle <= hd;
      req_now_seconds <= nw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // drain responses, then write the timeout register
   task automatic set_timeout(logic [TO_BITS-1:0] value);
      req_valid <= 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= CSR_ADDR_TIMEOUT;
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
   endtask

   function automatic key_type swap_dir(key_type k);
      return '{k.dst_addr, k.src_addr, k.dst_port, k.src_port, k.vlan_id};
   endfunction

   function automatic key_type random_key();
      key_type k;
      k.src_addr = $urandom;
      k.dst_addr = $urandom;
      k.src_port = $urandom;
      k.dst_port = $urandom;
      k.vlan_id  = $urandom;
      return k;
   endfunction

   // mostly pooled keys so that hits, replaces and expiry happen often
   task automatic send_random_flow();
      key_type                k;
      logic [KIND_BITS-1:0]   kind;
      logic [HANDLE_BITS-1:0] hd;
      int                     pick;
      pick = $urandom_range(99);
      if (pick < 48)      kind = KIND_INSERT;
      else if (pick < 80) kind = KIND_LOOKUP;
      else if (pick < 97) kind = KIND_DELETE;
      else                kind = KIND_RESERVED;
      if ($urandom_range(99) < 88) k = flow_pool[$urandom_range(POOL - 1)];
      else k = random_key();
      if ($urandom_range(1)) k = swap_dir(k);
      hd = ($urandom_range(99) < 3) ? '0 : $urandom;
      pick = $urandom_range(999);
      if (pick < 800)      now_s = now_s + $urandom_range(2);
      else if (pick < 985) now_s = now_s + $urandom_range(40);
      else if (pick < 995) now_s = now_s + $urandom;
      else                 now_s = now_s - $urandom_range(1, 100);
      send_flow(kind, k, hd, now_s);
   endtask

   initial begin
      key_type                ka, kb, kc;
      logic [TO_BITS-1:0]     timeouts [6];
      reset       = 1;
      csr_psel    = 0;
      csr_penable = 0;
      csr_pwrite  = 0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      req_valid   = 0;
      req_kind    = KIND_INSERT;
      req_src_addr = '0;
      req_dst_addr = '0;
      req_src_port = '0;
      req_dst_port = '0;
      req_vlan_id  = '0;
      req_data_handle = '0;
      req_now_seconds = '0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_off_go = 0;
      now_s = 32'd1000;
      timeouts = '{17'd60, 17'd86400, 17'd1, 17'd0, 17'd3000, 17'd60};
      for (int i = 0; i < POOL; i++) begin
         flow_pool[i] = random_key();
         if (i % 5 == 0) flow_pool[i].vlan_id = '0;
         if (i % 7 == 0) flow_pool[i].vlan_id = '1;
      end
      repeat (11) @(posedge clock);
      reset <= 0;

      // directed part under the reset timeout
      set_timeout(17'd60);
      ka = '{32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, 16'h0000, 12'hFFF};
      kb = '{32'h0, 32'h0, 16'h0, 16'h0, 12'h0};
      kc = '{32'h0A00_0001, 32'hC0A8_0001, 16'd443, 16'd65535, 12'd7};
      send_flow(KIND_INSERT, ka, 32'hFFFF_FFFF, now_s);
      send_flow(KIND_INSERT, kb, 32'h1, now_s);
      send_flow(KIND_INSERT, kc, 32'h0, now_s);          // null handle
      send_flow(KIND_LOOKUP, swap_dir(ka), 32'h0, now_s + 1);
      send_flow(KIND_LOOKUP, kc, 32'h0, now_s + 1);      // never inserted
      send_flow(KIND_INSERT, swap_dir(ka), 32'h5, now_s + 2);   // replace
      send_flow(KIND_DELETE, kb, 32'h0, now_s + 2);
      send_flow(KIND_DELETE, kb, 32'h0, now_s + 2);      // already gone
      send_flow(KIND_RESERVED, ka, 32'hDEAD_BEEF, now_s + 2);   // undefined kind
      send_flow(KIND_LOOKUP, ka, 32'h0, now_s + 62);     // age equals timeout
      now_s = now_s + 100;
      send_flow(KIND_INSERT, kc, 32'h8000_0000, now_s);
      send_flow(KIND_INSERT, kb, 32'h2, now_s);
      send_flow(KIND_LOOKUP, kc, 32'h0, now_s - 5);      // time ran backwards
      send_flow(KIND_LOOKUP, kb, 32'h0, now_s);
      send_flow(KIND_INSERT, '{32'h1, 32'h1, 16'h1, 16'h1, 12'hFFF}, 32'h7, 32'hFFFF_FFFF);
      send_flow(KIND_DELETE, '{32'h1, 32'h1, 16'h1, 16'h1, 12'hFFF}, 32'h0, 32'h0);
      now_s = now_s + 200;

      // random phases across timeout settings and idle patterns
      for (int ph = 0; ph < 6; ph++) begin
         set_timeout(timeouts[ph]);
         case (ph % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 85; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 85; end
            default: begin sender_idle_pct = 20; receiver_stall_pct = 20; end
         endcase
         for (int n = 0; n < 305; n++) begin
            if (n == 150 && ph == 1) begin
               sender_idle_pct = 0;
               hold_off_go = 1;
            end
            send_random_flow();
         end
      end

      // drain and give the verdict
      req_valid <= 0;
      receiver_stall_pct = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
